// ===== src/multi_channel_watchdog_table_macros.svh =====
// ----------------------------------------------------------------------------
// Multi-channel watchdog table assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_WATCHDOG_TABLE_MACROS_SVH
`define MULTI_CHANNEL_WATCHDOG_TABLE_MACROS_SVH

// same-cycle implication
`define MCWT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcwt assertion failed");

// next-cycle implication
`define MCWT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcwt assertion failed");

`endif

// ===== src/mcwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel watchdog table package
// Table size, request and status codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcwt_pkg;

	// table geometry
	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// field widths
	localparam int KIND_W   = 2;
	localparam int ID_W     = 16;
	localparam int TICK_W   = 32;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 8;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FEED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // capture input word, reset walk
		logic step;  // evaluate current entry, advance index
		logic emit;  // move result into output register
	} mcwt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic walk_done;  // current step ends the table walk
		logic walk_last;  // current step is at the last entry
	} mcwt_stat_t;

endpackage

// ===== src/mcwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Watchdog table controller
// Sequences accept, table walk and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcwt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mcwt_pkg::mcwt_stat_t stat,
	output mcwt_pkg::mcwt_cmd_t  cmd
);
	import mcwt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_WALK;
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (stat.walk_done || stat.walk_last) begin
					state_nxt = S_HOLD;
				end
			end
			S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/mcwt_dp.sv =====
// ----------------------------------------------------------------------------
// Watchdog table datapath
// Entry table, tick counter, per-entry match and expiry logic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcwt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mcwt_pkg::mcwt_cmd_t             cmd,
	input  logic [mcwt_pkg::KIND_W-1:0]     in_kind,
	input  logic [mcwt_pkg::ID_W-1:0]       in_client_id,
	input  logic [mcwt_pkg::TICK_W-1:0]     in_period,
	output mcwt_pkg::mcwt_stat_t            stat,
	output logic [mcwt_pkg::OUT_W-1:0]      out_data
);
	import mcwt_pkg::*;

	// captured request
	logic [KIND_W-1:0]   kind_q;
	logic [ID_W-1:0]     id_q;
	logic [TICK_W-1:0]   period_q;
	logic [IDX_W-1:0]    idx_q;
	logic [STATUS_W-1:0] status_q;
	logic                expired_q;
	logic [TICK_W-1:0]   tick_q;

	// table
	logic [ENTRIES-1:0]  used_q;
	logic [ID_W-1:0]     client_q [ENTRIES];
	logic [TICK_W-1:0]   tperiod_q [ENTRIES];
	logic [TICK_W-1:0]   last_q [ENTRIES];

	// result register
	logic [STATUS_W-1:0] out_status_q;
	logic                out_expired_q;

	// per-entry evaluation
	logic              skip;
	logic              match;
	logic              claim;
	logic              found;
	logic              is_last;
	logic [TICK_W-1:0] age;
	logic              timed_out;

	always_comb begin
		skip      = (kind_q == KIND_TICK) || ((kind_q == KIND_START) && (id_q == '0));
		match     = used_q[idx_q] && (client_q[idx_q] == id_q);
		claim     = (kind_q == KIND_START) && !skip && !used_q[idx_q];
		found     = (kind_q == KIND_QUERY) && match;
		is_last   = (idx_q == IDX_W'(ENTRIES - 1));
		age       = tick_q - last_q[idx_q];
		timed_out = (age > tperiod_q[idx_q]);
	end

	assign stat.walk_done = skip || claim || found;
	assign stat.walk_last = is_last;

	// request capture, walk index, running result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			status_q  <= STATUS_OK;
			expired_q <= 1'b0;
			kind_q    <= KIND_TICK;
		end else if (cmd.load) begin
			idx_q     <= '0;
			kind_q    <= in_kind;
			expired_q <= 1'b0;
			if (in_kind == KIND_START) begin
				status_q <= (in_client_id == '0) ? STATUS_INVALID : STATUS_FULL;
			end else begin
				status_q <= STATUS_OK;
			end
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (claim) begin
				status_q <= STATUS_OK;
			end
			if (found) begin
				expired_q <= timed_out;
			end
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q     <= in_client_id;
			period_q <= in_period;
		end
	end

	// tick counter, advanced by tick requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (cmd.load && (in_kind == KIND_TICK)) begin
			tick_q <= tick_q + TICK_W'(1);
		end
	end

	// entry occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.step && claim) begin
			used_q[idx_q] <= 1'b1;
		end
	end

	// entry contents, written at the walk index
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (claim) begin
				client_q[idx_q]  <= id_q;
				tperiod_q[idx_q] <= period_q;
				last_q[idx_q]    <= tick_q;
			end else if ((kind_q == KIND_FEED) && match) begin
				last_q[idx_q] <= tick_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q  <= status_q;
			out_expired_q <= expired_q;
		end
	end

	assign out_data = {{(OUT_W - STATUS_W - 1){1'b0}}, out_expired_q, out_status_q};

endmodule

// ===== src/multi_channel_watchdog_table.sv =====
// A result word is offered after its request is accepted, once the controller has walked the
// table entries in order to the end of the walk and handed the result on; output stalls add to it.
// One request at a time: no new request is accepted until the walk and the hand-off are done.
// Tick requests and start with id zero end the walk at the first entry.
// Reset (arst_n low) clears the tick counter, all entry used bits and the output valid.
// ----------------------------------------------------------------------------
// Multi-channel watchdog table
// Table of per-client watchdog entries with start, feed, query and tick requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_channel_watchdog_table_macros.svh"

module multi_channel_watchdog_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [mcwt_pkg::IN_W-1:0]     s_axis_tdata,   // [15:0] client_id, [47:16] timeout_period
	input  logic [mcwt_pkg::KIND_W-1:0]   s_axis_tuser,   // [1:0] kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [mcwt_pkg::OUT_W-1:0]    m_axis_tdata    // [1:0] status, [2] expired, [7:3] zero
);
	import mcwt_pkg::*;

	mcwt_cmd_t  cmd;
	mcwt_stat_t stat;

	// output word fields, for checking
	logic [STATUS_W-1:0] out_status;
	logic                out_expired;
	logic                status_known;

	mcwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcwt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_kind      (s_axis_tuser),
		.in_client_id (s_axis_tdata[ID_W-1:0]),
		.in_period    (s_axis_tdata[ID_W+TICK_W-1:ID_W]),
		.stat         (stat),
		.out_data     (m_axis_tdata)
	);

	assign out_status   = m_axis_tdata[STATUS_W-1:0];
	assign out_expired  = m_axis_tdata[STATUS_W];
	assign status_known = out_status inside {STATUS_OK, STATUS_INVALID, STATUS_FULL};

	// result register never overwritten while a word is still pending
	`MCWT_ASSERT_NOW(a_emit_free, cmd.emit, (!m_axis_tvalid || m_axis_tready))
	// one request in flight: no accept in the cycle after an accept
	`MCWT_ASSERT_NEXT(a_one_inflight, (s_axis_tvalid && s_axis_tready), !s_axis_tready)
	// expiry is only reported together with an ok status
	`MCWT_ASSERT_NOW(a_expired_ok, (m_axis_tvalid && out_expired), (out_status == STATUS_OK))
	// status is always a defined code
	`MCWT_ASSERT_NOW(a_status_code, m_axis_tvalid, status_known)

endmodule
